[rtl/prf_pkg.sv]
// Package: shared constants and item types for the permutation rank core.
package prf_pkg;

    localparam int MAX_LEN   = 32;
    localparam int VAL_W     = $clog2(MAX_LEN);
    localparam int POS_W     = $clog2(MAX_LEN) + 1;
    localparam int RANK_LO_W = 64;
    localparam int RANK_HI_W = 54;
    localparam int ACC_W     = RANK_LO_W + RANK_HI_W;

    typedef logic [ACC_W-1:0]   t_acc;
    typedef logic [MAX_LEN-1:0] t_map;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
    } t_in_item;

    typedef struct packed {
        logic [RANK_LO_W-1:0] rank_low;
        logic [RANK_HI_W-1:0] rank_high;
        logic [POS_W-1:0]     length;
        logic                 invalid;
    } t_out_item;

endpackage

[rtl/prf_in_if.sv]
// Interface: input element channel with valid/ready handshake.
interface prf_in_if import prf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/prf_out_if.sv]
// Interface: rank result channel with valid/ready handshake.
interface prf_out_if import prf_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/prf_digit.sv]
// Lehmer digit: count of seen values below the new value, plus duplicate check.
module prf_digit import prf_pkg::*; (
    input  t_map             i_seen,
    input  logic [VAL_W-1:0] i_value,
    output logic [VAL_W-1:0] o_digit,
    output logic             o_dup
);

    t_map             w_below;
    logic [POS_W-1:0] w_cnt;

    always_comb begin
        w_below = i_seen & ((t_map'(1) << i_value) - t_map'(1));
        w_cnt   = '0;
        for (int i = 0; i < MAX_LEN; i++) begin
            w_cnt = w_cnt + POS_W'(w_below[i]);
        end
    end

    assign o_digit = w_cnt[VAL_W-1:0];
    assign o_dup   = i_seen[i_value];

endmodule

[rtl/prf_acc.sv]
// Rank accumulator step: acc * mul + add, kept to the accumulator width.
module prf_acc import prf_pkg::*; (
    input  t_acc             i_acc,
    input  logic [POS_W-1:0] i_mul,
    input  logic [VAL_W-1:0] i_add,
    output t_acc             o_acc
);

    logic [ACC_W+POS_W-1:0] w_prod;

    assign w_prod = ({{POS_W{1'b0}}, i_acc} * {{ACC_W{1'b0}}, i_mul})
                    + (ACC_W+POS_W)'(i_add);
    assign o_acc  = w_prod[ACC_W-1:0];

endmodule

[rtl/permutation_rank_factoradic_core.sv]
// Top level: permutation rank core with input register and result register.
// Order: a last element waits in the input register, then its result is registered as valid.
// Throughput: one element per cycle; a last element stalls the input only while an
// unaccepted result holds the result register. Loop: popcount and 118x6 multiply-add.
// Reset: synchronous active-low i_rst_n clears all permutation state and both
// valid flags; the block accepts items on the first cycle after reset.
module permutation_rank_factoradic_core import prf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    prf_in_if.sink    i_in,
    prf_out_if.source o_out
);

    logic             r_in_vld;
    t_in_item         r_in_item;
    logic             r_out_vld;
    t_out_item        r_out_item;

    t_map             r_seen;
    logic [POS_W-1:0] r_pos;
    t_acc             r_acc;
    logic [VAL_W-1:0] r_largest;
    logic             r_err;

    logic             w_adv;
    logic             w_in_acc;
    logic [VAL_W-1:0] w_digit;
    logic             w_dup;
    t_acc             w_acc;
    logic             w_full;

    t_map             n_seen;
    logic [POS_W-1:0] n_pos;
    t_acc             n_acc;
    logic [VAL_W-1:0] n_largest;
    logic             n_err;
    logic             n_bad;
    t_out_item        n_out;

    assign w_adv    = r_in_vld && (!r_in_item.last || !r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_adv;
    assign w_in_acc = i_in.valid && i_in.ready;

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out_item;

    prf_digit u_digit (
        .i_seen  (r_seen),
        .i_value (r_in_item.value),
        .o_digit (w_digit),
        .o_dup   (w_dup)
    );

    prf_acc u_acc (
        .i_acc (r_acc),
        .i_mul (r_pos + POS_W'(1)),
        .i_add (w_digit),
        .o_acc (w_acc)
    );

    assign w_full = (r_pos >= POS_W'(MAX_LEN));

    always_comb begin
        if (w_full) begin
            n_seen    = r_seen;
            n_pos     = r_pos;
            n_acc     = r_acc;
            n_largest = r_largest;
            n_err     = 1'b1;
        end else begin
            n_seen    = r_seen | (t_map'(1) << r_in_item.value);
            n_pos     = r_pos + POS_W'(1);
            n_acc     = w_acc;
            n_largest = (r_in_item.value > r_largest) ? r_in_item.value : r_largest;
            n_err     = r_err | w_dup;
        end
        n_bad           = n_err || ({1'b0, n_largest} >= n_pos);
        n_out.rank_low  = n_bad ? '0 : n_acc[RANK_LO_W-1:0];
        n_out.rank_high = n_bad ? '0 : n_acc[ACC_W-1:RANK_LO_W];
        n_out.length    = n_pos;
        n_out.invalid   = n_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_seen    <= '0;
            r_pos     <= '0;
            r_acc     <= '0;
            r_largest <= '0;
            r_err     <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end

            if (w_adv && r_in_item.last) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end

            if (w_adv) begin
                if (r_in_item.last) begin
                    r_seen    <= '0;
                    r_pos     <= '0;
                    r_acc     <= '0;
                    r_largest <= '0;
                    r_err     <= 1'b0;
                end else begin
                    r_seen    <= n_seen;
                    r_pos     <= n_pos;
                    r_acc     <= n_acc;
                    r_largest <= n_largest;
                    r_err     <= n_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_item <= i_in.data;
        end
        if (w_adv && r_in_item.last) begin
            r_out_item <= n_out;
        end
    end

endmodule

[bench/permutation_rank_factoradic_core_tb.sv]
// Testbench: permutation rank core against a behavioral rank predictor.
module permutation_rank_factoradic_core_tb;
    import prf_pkg::*;

    typedef enum int {PERM_GOOD, PERM_DUP, PERM_RANGE, PERM_LONG, PERM_NOISE} t_perm_kind;

    logic clk = 1'b0;
    logic rst_n;

    prf_in_if  in_ch ();
    prf_out_if out_ch ();

    permutation_rank_factoradic_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #1 clk = ~clk;

    // rank predictor state
    t_map seen_vals;
    int   elem_cnt;
    t_acc rank_acc;
    int   top_val;
    bit   dup_or_long;

    t_out_item         pending_ranks[$];
    logic [VAL_W-1:0]  perm_buf[$];
    int                items_sent;
    int                errors;

    function automatic void clear_rank();
        seen_vals   = '0;
        elem_cnt    = 0;
        rank_acc    = '0;
        top_val     = 0;
        dup_or_long = 1'b0;
    endfunction

    function automatic void rank_step(input logic [VAL_W-1:0] v, input logic l);
        int        digit;
        bit        bad;
        t_out_item r;
        if (elem_cnt >= MAX_LEN) begin
            dup_or_long = 1'b1;
        end else begin
            digit = $countones(seen_vals & ((t_map'(1) << v) - t_map'(1)));
            if (seen_vals[v])
                dup_or_long = 1'b1;
            seen_vals[v] = 1'b1;
            if (int'(v) > top_val)
                top_val = int'(v);
            rank_acc = rank_acc * t_acc'(elem_cnt + 1) + t_acc'(digit);
            elem_cnt++;
        end
        if (l) begin
            bad         = dup_or_long || (top_val >= elem_cnt);
            r.rank_low  = bad ? '0 : rank_acc[RANK_LO_W-1:0];
            r.rank_high = bad ? '0 : rank_acc[ACC_W-1:RANK_LO_W];
            r.length    = POS_W'(elem_cnt);
            r.invalid   = bad;
            pending_ranks.push_back(r);
            clear_rank();
        end
    endfunction

    task automatic send_elem(input logic [VAL_W-1:0] v, input logic l);
        int gap;
        gap = $urandom_range(0, 10);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data.value <= v;
        in_ch.data.last  <= l;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        rank_step(v, l);
        items_sent++;
    endtask

    task automatic send_buf();
        int i;
        for (i = 0; i < perm_buf.size(); i++)
            send_elem(perm_buf[i], i == perm_buf.size() - 1);
    endtask

    task automatic fill_perm(input int n, input bit reversed);
        int i;
        int j;
        logic [VAL_W-1:0] t;
        perm_buf.delete();
        for (i = 0; i < n; i++)
            perm_buf.push_back(reversed ? VAL_W'(n - 1 - i) : VAL_W'(i));
        if (reversed)
            return;
        for (i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm_buf[i];
            perm_buf[i] = perm_buf[j];
            perm_buf[j] = t;
        end
    endtask

    task automatic test_short_cases();
        send_elem(0, 1'b1);
        send_elem(1, 1'b0); send_elem(0, 1'b1);
        // duplicate
        send_elem(0, 1'b0); send_elem(0, 1'b1);
        // value not below length
        send_elem(2, 1'b0); send_elem(0, 1'b1);
        send_elem(31, 1'b1);
        // duplicate of an earlier, larger value
        send_elem(2, 1'b0); send_elem(0, 1'b0); send_elem(2, 1'b1);
        send_elem(2, 1'b0); send_elem(0, 1'b0); send_elem(3, 1'b0); send_elem(1, 1'b1);
        send_elem(0, 1'b0); send_elem(1, 1'b0); send_elem(2, 1'b1);
    endtask

    task automatic test_longest();
        // smallest rank: 0
        fill_perm(MAX_LEN, 1'b1);
        send_buf();
        fill_perm(MAX_LEN, 1'b0);
        send_buf();
        // one element past the limit, then a clean permutation after it
        fill_perm(MAX_LEN, 1'b0);
        perm_buf.push_back(VAL_W'(0));
        send_buf();
        fill_perm(3, 1'b0);
        send_buf();
    endtask

    task automatic test_random_perms();
        t_perm_kind kind;
        int pick;
        int n;
        int a;
        int b;
        int i;
        while (items_sent < 450) begin
            pick = $urandom_range(0, 99);
            kind = pick < 75 ? PERM_GOOD : pick < 82 ? PERM_DUP : pick < 89 ? PERM_RANGE :
                   pick < 94 ? PERM_LONG : PERM_NOISE;
            n = ($urandom_range(0, 3) == 0) ? MAX_LEN : $urandom_range(1, MAX_LEN);
            case (kind)
                PERM_GOOD: begin
                    fill_perm(n, $urandom_range(0, 9) == 0);
                end
                PERM_DUP: begin
                    if (n < 2)
                        n = 2;
                    fill_perm(n, 1'b0);
                    a = $urandom_range(0, n - 1);
                    b = (a + $urandom_range(1, n - 1)) % n;
                    perm_buf[a] = perm_buf[b];
                end
                PERM_RANGE: begin
                    if (n == MAX_LEN)
                        n = MAX_LEN - 1;
                    fill_perm(n, 1'b0);
                    perm_buf[$urandom_range(0, n - 1)] = VAL_W'($urandom_range(n, MAX_LEN - 1));
                end
                PERM_LONG: begin
                    fill_perm(MAX_LEN, 1'b0);
                    repeat ($urandom_range(1, 4))
                        perm_buf.push_back(VAL_W'($urandom_range(0, MAX_LEN - 1)));
                end
                default: begin
                    perm_buf.delete();
                    n = $urandom_range(1, 8);
                    for (i = 0; i < n; i++)
                        perm_buf.push_back(VAL_W'($urandom_range(0, MAX_LEN - 1)));
                end
            endcase
            send_buf();
        end
    endtask

    // result side
    initial begin
        int        stall;
        t_out_item want;
        t_out_item got;
        out_ch.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (out_ch.valid !== 1'b1);
            got = out_ch.data;
            if (pending_ranks.size() == 0) begin
                $display("%0t: unexpected result: got %h", $time, got);
                errors++;
            end else begin
                want = pending_ranks.pop_front();
                if (got.rank_low !== want.rank_low) begin
                    $display("%0t: rank_low expected %h got %h", $time, want.rank_low,
                             got.rank_low);
                    errors++;
                end
                if (got.rank_high !== want.rank_high) begin
                    $display("%0t: rank_high expected %h got %h", $time, want.rank_high,
                             got.rank_high);
                    errors++;
                end
                if (got.length !== want.length) begin
                    $display("%0t: length expected %0d got %0d", $time, want.length,
                             got.length);
                    errors++;
                end
                if (got.invalid !== want.invalid) begin
                    $display("%0t: invalid expected %b got %b", $time, want.invalid,
                             got.invalid);
                    errors++;
                end
            end
        end
    end

    initial begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        errors     = 0;
        items_sent = 0;
        clear_rank();
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        rst_n       <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_short_cases();
        test_longest();
        test_random_perms();

        in_ch.valid <= 1'b0;
        while (pending_ranks.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
